/* sv/pfs_pkg.sv */
// Package for the packet frame synchroniser: shared types and constants.
// No dependencies; imported by every module of the block.
package pfs_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOOTER_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOSS_LIMIT    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0] DELIMITER_RESET     = 8'h24;
    localparam logic [7:0] FOOTER_FIRST_RESET  = 8'h0D;
    localparam logic [7:0] FOOTER_SECOND_RESET = 8'h0A;
    localparam logic [7:0] LOSS_LIMIT_RESET    = 8'd3;

    // Status reported with every dispatched byte: locked to the stream.
    localparam logic [1:0] STATUS_SYNC = 2'd2;

    // Packet buffer is split into three banks used in rotation.
    localparam int NUM_BANKS = 3;

    typedef logic [1:0] bank_t;

    typedef struct packed {
        logic [7:0] delimiter;
        logic [7:0] footer_first;
        logic [7:0] footer_second;
        logic [7:0] loss_limit;
    } cfg_t;

    typedef struct packed {
        logic       en;
        bank_t      bank;
        logic [7:0] data;
    } buf_wr_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] idx;
        logic       last;
    } out_item_t;

endpackage

/* sv/packet_frame_synchronizer_unit.sv */
// Packet frame synchroniser, top level. A packet's first byte passes the command
// queue, bank register, read register and output queue; unless stalled, the rest
// follow one a cycle. Throughput, unless stalled: a stream byte per cycle in and
// a packet byte per cycle out; three banks hold up to three packets against stall.
// Reset: registers take their defaults, the block searches with empty queues;
// the buffer is not cleared, as no byte is read before it has been written.
module packet_frame_synchronizer_unit
    import pfs_pkg::*;
#(
    parameter int PACKET_BYTES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             packet_byte,
    output logic [3:0]             byte_index,
    output logic                   last_byte,
    output logic [1:0]             sync_status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam int IDX_W = $clog2(PACKET_BYTES);

    // The front end takes one item per cycle while the command queue has room,
    // checks each completed window against the delimiter and footer and runs the
    // sync state machine. Only good windows seen while synchronised are passed on,
    // as a bank number in the command queue; the bytes themselves were written into
    // that bank of the packet buffer as they arrived. The back end reads a bank out
    // one byte a cycle, while there is room, into a small output queue, so output
    // stall never reaches the front end until all three banks are taken.

    cfg_t             cfg_reg;
    logic             cmd_push;
    bank_t            cmd_bank;
    logic             cmd_pop;
    logic             cmd_full;
    logic             cmd_empty;
    bank_t            cmd_head;
    buf_wr_t          buf_wr;
    logic [IDX_W-1:0] buf_wr_idx;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter     <= DELIMITER_RESET;
            cfg_reg.footer_first  <= FOOTER_FIRST_RESET;
            cfg_reg.footer_second <= FOOTER_SECOND_RESET;
            cfg_reg.loss_limit    <= LOSS_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DELIMITER:     cfg_reg.delimiter     <= cfg_data;
                REG_FOOTER_FIRST:  cfg_reg.footer_first  <= cfg_data;
                REG_FOOTER_SECOND: cfg_reg.footer_second <= cfg_data;
                REG_LOSS_LIMIT:    cfg_reg.loss_limit    <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    pfs_front #(
        .P(PACKET_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .cfg        (cfg_reg),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_bank   (cmd_bank),
        .buf_wr     (buf_wr),
        .buf_wr_idx (buf_wr_idx)
    );

    pfs_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_bank (cmd_bank),
        .pop       (cmd_pop),
        .full      (cmd_full),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    pfs_back #(
        .P(PACKET_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .buf_wr      (buf_wr),
        .buf_wr_idx  (buf_wr_idx),
        .cmd_empty   (cmd_empty),
        .cmd_head    (cmd_head),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_byte (packet_byte),
        .byte_index  (byte_index),
        .last_byte   (last_byte),
        .sync_status (sync_status)
    );

    // A packet is never dispatched into a full command queue.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !cmd_full)
        else $error("dispatch pushed into a full command queue");

    // The dispatcher only takes a command that is there.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("dispatcher popped an empty command queue");

    // The end-of-packet marker sits on the final byte position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_byte) |-> (byte_index == 4'(PACKET_BYTES - 1)))
        else $error("last byte marker on the wrong byte position");

endmodule

/* sv/pfs_front.sv */
// Front end of the packet frame synchroniser: byte intake, window check
// and the sync state machine. Depends on pfs_pkg.
module pfs_front
    import pfs_pkg::*;
#(
    parameter int P = 16,
    localparam int IDX_W = $clog2(P)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  cfg_t             cfg,
    input  logic             cmd_full,
    output logic             cmd_push,
    output bank_t            cmd_bank,
    output buf_wr_t          buf_wr,
    output logic [IDX_W-1:0] buf_wr_idx
);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CONFIRM,
        PH_SYNC,
        PH_LOSS
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] skip_reg, skip_next;
    logic [7:0]       bad_reg, bad_next;
    bank_t            bank_reg, bank_next;
    logic [7:0]       window_reg [P-1];

    logic             accept;
    logic             store;
    logic             window_good;
    logic             found;
    logic [IDX_W-1:0] found_pos;
    logic [7:0]       bad_inc;

    assign in_stall = cmd_full;
    assign accept   = in_valid & ~cmd_full;
    assign store    = accept & (skip_reg == '0);

    // The last byte of the window is the one arriving now.
    assign window_good = (window_reg[0] == cfg.delimiter) &&
                         (window_reg[P-2] == cfg.footer_first) &&
                         (data_byte == cfg.footer_second);

    // First delimiter at offsets 1 and up; lower offsets override higher ones.
    always_comb
    begin
        found     = (data_byte == cfg.delimiter);
        found_pos = IDX_W'(P - 1);
        for (int i = P - 2; i >= 1; i--)
        begin
            if (window_reg[i] == cfg.delimiter)
            begin
                found     = 1'b1;
                found_pos = IDX_W'(i);
            end
        end
    end

    assign bad_inc = (bad_reg == 8'hFF) ? bad_reg : bad_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        skip_next  = skip_reg;
        bad_next   = bad_reg;
        bank_next  = bank_reg;
        cmd_push   = 1'b0;
        cmd_bank   = bank_reg;
        buf_wr.en   = store;
        buf_wr.bank = bank_reg;
        buf_wr.data = data_byte;
        buf_wr_idx  = fill_reg;

        if (accept)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - IDX_W'(1);
            end
            else if (fill_reg != IDX_W'(P - 1))
            begin
                fill_next = fill_reg + IDX_W'(1);
            end
            else
            begin
                fill_next = '0;
                unique case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (window_good)
                        begin
                            phase_next = PH_CONFIRM;
                        end
                        else if (found)
                        begin
                            skip_next  = found_pos;
                            phase_next = PH_CONFIRM;
                        end
                    end
                    PH_CONFIRM:
                    begin
                        phase_next = window_good ? PH_SYNC : PH_SEARCH;
                    end
                    PH_SYNC:
                    begin
                        if (window_good)
                        begin
                            cmd_push  = 1'b1;
                            bank_next = (bank_reg == bank_t'(NUM_BANKS - 1)) ?
                                        '0 : bank_reg + bank_t'(1);
                        end
                        else
                        begin
                            bad_next   = 8'd1;
                            phase_next = PH_LOSS;
                        end
                    end
                    PH_LOSS:
                    begin
                        if (window_good)
                        begin
                            phase_next = PH_SYNC;
                        end
                        else
                        begin
                            bad_next = bad_inc;
                            if (bad_inc >= cfg.loss_limit)
                            begin
                                phase_next = PH_SEARCH;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SEARCH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            fill_reg  <= '0;
            skip_reg  <= '0;
            bad_reg   <= '0;
            bank_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            skip_reg  <= skip_next;
            bad_reg   <= bad_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            for (int i = 0; i < P - 1; i++)
            begin
                if (fill_reg == IDX_W'(i))
                begin
                    window_reg[i] <= data_byte;
                end
            end
        end
    end

endmodule

/* sv/pfs_cmd_queue.sv */
// Two-entry queue of dispatch commands (packet buffer bank numbers)
// between the front end and the dispatcher. Depends on pfs_pkg.
module pfs_cmd_queue
    import pfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  bank_t push_bank,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output bank_t head
);

    bank_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_bank;
        end
    end

endmodule

/* sv/pfs_back.sv */
// Back end of the packet frame synchroniser: three-bank packet buffer,
// byte dispatcher and two-entry output queue. Depends on pfs_pkg.
module pfs_back
    import pfs_pkg::*;
#(
    parameter int P = 16,
    localparam int IDX_W = $clog2(P),
    localparam int ADDR_W = $clog2(NUM_BANKS * P)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  buf_wr_t          buf_wr,
    input  logic [IDX_W-1:0] buf_wr_idx,
    input  logic             cmd_empty,
    input  bank_t            cmd_head,
    output logic             cmd_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       packet_byte,
    output logic [3:0]       byte_index,
    output logic             last_byte,
    output logic [1:0]       sync_status
);

    logic [7:0]       mem [NUM_BANKS * P];
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    logic             active_reg, active_next;
    bank_t            bank_reg, bank_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_valid_reg;
    logic [7:0]       rdata_reg;
    logic [3:0]       rd_meta_idx_reg;
    logic             rd_meta_last_reg;

    out_item_t        item_reg [2];
    logic             owr_ptr_reg, ord_ptr_reg;
    logic [1:0]       ocount_reg;

    logic             issue;
    logic             issue_last;
    logic             start;
    logic             pop;
    logic [2:0]       level;
    out_item_t        head_item;

    assign wr_addr = ADDR_W'(buf_wr.bank) * ADDR_W'(P) + ADDR_W'(buf_wr_idx);
    assign rd_addr = ADDR_W'(bank_reg) * ADDR_W'(P) + ADDR_W'(rd_idx_reg);

    // Output queue occupancy once this cycle's pop is taken into account.
    assign pop   = out_valid & ~out_stall;
    assign level = 3'(ocount_reg) + 3'(rd_valid_reg) - 3'(pop);

    assign issue      = active_reg & (level < 3'd2);
    assign issue_last = issue & (rd_idx_reg == IDX_W'(P - 1));
    assign start      = ~cmd_empty & (~active_reg | issue_last);
    assign cmd_pop    = start;

    always_comb
    begin
        active_next = active_reg;
        bank_next   = bank_reg;
        rd_idx_next = rd_idx_reg;
        if (issue)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
            if (issue_last)
            begin
                active_next = 1'b0;
            end
        end
        if (start)
        begin
            active_next = 1'b1;
            bank_next   = cmd_head;
            rd_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            bank_reg     <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            owr_ptr_reg  <= 1'b0;
            ord_ptr_reg  <= 1'b0;
            ocount_reg   <= 2'd0;
        end
        else
        begin
            active_reg   <= active_next;
            bank_reg     <= bank_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= issue;
            if (rd_valid_reg)
            begin
                owr_ptr_reg <= ~owr_ptr_reg;
            end
            if (pop)
            begin
                ord_ptr_reg <= ~ord_ptr_reg;
            end
            ocount_reg <= ocount_reg + 2'(rd_valid_reg) - 2'(pop);
        end
    end

    // Packet buffer: one write port for the front end, one read port here.
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            mem[wr_addr] <= buf_wr.data;
        end
        if (issue)
        begin
            rdata_reg        <= mem[rd_addr];
            rd_meta_idx_reg  <= 4'(rd_idx_reg);
            rd_meta_last_reg <= (rd_idx_reg == IDX_W'(P - 1));
        end
        if (rd_valid_reg)
        begin
            item_reg[owr_ptr_reg] <= '{data: rdata_reg,
                                       idx:  rd_meta_idx_reg,
                                       last: rd_meta_last_reg};
        end
    end

    assign head_item   = item_reg[ord_ptr_reg];
    assign out_valid   = (ocount_reg != 2'd0);
    assign packet_byte = head_item.data;
    assign byte_index  = head_item.idx;
    assign last_byte   = head_item.last;
    assign sync_status = STATUS_SYNC;

endmodule
